[hw/rtl/blfa_pkg.sv]
// ----------------------------------------------------------------------------
// blfa_pkg
// Shared constants, codes and types of the lowest-free bitmap allocator.
// ----------------------------------------------------------------------------
package blfa_pkg;

  localparam int CAPACITY = 1024;
  localparam int WORD_W   = 32;
  localparam int WORDS    = CAPACITY / WORD_W;
  localparam int ADDR_W   = $clog2(WORDS);
  localparam int BIT_W    = $clog2(WORD_W);
  localparam int NUM_W    = 11;
  localparam int IDX_W    = 10;
  localparam int CFG_W    = 11;
  localparam int CFGI_W   = 2;

  // request kinds
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_RESERVE = 2'd2;

  // result status
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NONE_FREE = 2'd1;
  localparam logic [1:0] ST_IN_USE    = 2'd2;

  // configuration register indexes
  localparam logic [CFGI_W-1:0] CFG_TOTAL_ITEMS     = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_FIRST_CANDIDATE = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_INITIAL_FREE    = 2'd2;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } map_req_t;

  // index of the lowest set bit; 0 when none is set
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] one;
    logic [BIT_W-1:0]  idx;
    one = x & (~x + WORD_W'(1));
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (one[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[hw/rtl/blfa_map.sv]
// ----------------------------------------------------------------------------
// blfa_map
// Usage bitmap held as a word memory, with per-row valid bits and a
// per-row full summary.
// ----------------------------------------------------------------------------
module blfa_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  blfa_pkg::map_req_t            req,
  output logic [blfa_pkg::WORD_W-1:0]   rd_data,
  output logic [blfa_pkg::WORDS-1:0]    full
);

  logic [blfa_pkg::WORD_W-1:0] mem [blfa_pkg::WORDS];
  logic [blfa_pkg::WORD_W-1:0] rd_data_r;
  logic                        rd_valid_r;
  logic [blfa_pkg::WORDS-1:0]  row_valid_r;
  logic [blfa_pkg::WORDS-1:0]  full_r;

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      row_valid_r <= '0;
      full_r      <= '0;
    end else begin
      if (req.rd_en) begin
        rd_valid_r <= row_valid_r[req.rd_addr];
      end
      if (req.wr_en) begin
        row_valid_r[req.wr_addr] <= 1'b1;
        full_r[req.wr_addr]      <= &req.wr_data;
      end
    end
  end

  // a row never written reads as all free
  assign rd_data = rd_valid_r ? rd_data_r : '0;
  assign full    = full_r;

endmodule

[hw/rtl/bitmap_lowest_free_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_lowest_free_allocator_unit
// Lowest-free first-fit allocator over a 1024-entry usage bitmap with a
// saturating free counter.
// ----------------------------------------------------------------------------
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+--------------
//  in      | in_req_type, in_item_number                   | valid / stall
//  out     | out_result_number, out_status, out_free_left  | valid / stall
//  cfg     | cfg_index, cfg_wdata                          | cfg_we
//
// Free and reserve pass through S_FIND, S_CHK and S_OUT; a number out of
// range skips S_CHK. An allocate reads at most two rows, picked through the
// per-row full summary: only the first row and the partial last row can
// miss, and a miss goes from S_CHK back to S_FIND. Out_stall can hold a
// result in S_OUT. One request in flight; a new word is accepted while the
// previous result waits. Reset clears the map at once through per-row valid bits.
// ----------------------------------------------------------------------------
module bitmap_lowest_free_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [blfa_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [blfa_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [blfa_pkg::NUM_W-1:0]     in_item_number,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [blfa_pkg::NUM_W-1:0]     out_result_number,
  output logic [1:0]                     out_status,
  output logic [blfa_pkg::NUM_W-1:0]     out_free_left
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIND = 4'b0010,
    S_CHK  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  localparam logic [blfa_pkg::NUM_W-1:0] CAP_N = blfa_pkg::NUM_W'(blfa_pkg::CAPACITY);

  state_t                          state_r, state_nxt;
  logic [1:0]                      kind_r;
  logic [blfa_pkg::NUM_W-1:0]      num_r;
  logic [blfa_pkg::WORDS-1:0]      tried_r, tried_nxt;
  logic [blfa_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  logic [blfa_pkg::NUM_W-1:0]      res_num_r, res_num_nxt;
  logic [1:0]                      res_st_r, res_st_nxt;
  logic [blfa_pkg::NUM_W-1:0]      free_cnt_r, free_cnt_nxt;
  logic [blfa_pkg::NUM_W-1:0]      total_r;
  logic [blfa_pkg::IDX_W-1:0]      first_r;
  logic                            out_valid_r;
  logic [blfa_pkg::NUM_W-1:0]      out_num_r;
  logic [1:0]                      out_st_r;
  logic [blfa_pkg::NUM_W-1:0]      out_free_r;

  blfa_pkg::map_req_t              map_req;
  logic [blfa_pkg::WORD_W-1:0]     word;
  logic [blfa_pkg::WORDS-1:0]      full;

  logic [blfa_pkg::NUM_W-1:0]      limit;
  logic [blfa_pkg::ADDR_W:0]       lim_words;
  logic [blfa_pkg::WORDS-1:0]      word_ok;
  logic [blfa_pkg::WORDS-1:0]      cand;
  logic [blfa_pkg::NUM_W-1:0]      num_m1;
  logic                            num_ok;
  logic [blfa_pkg::WORD_W-1:0]     lo_mask, hi_mask, avail, avail_one, num_one;
  logic [blfa_pkg::BIT_W-1:0]      avail_bit;
  logic                            in_acc, out_take;

  blfa_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .rd_data (word),
    .full    (full)
  );

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_take = !out_valid_r || !out_stall;

  // scan limit: total clipped to capacity, rounded down to a multiple of 8
  always_comb begin
    limit = (total_r > CAP_N) ? CAP_N : total_r;
    limit[2:0] = 3'b000;
    lim_words = limit[blfa_pkg::NUM_W-1:blfa_pkg::BIT_W]
              + (blfa_pkg::ADDR_W+1)'(|limit[blfa_pkg::BIT_W-1:0]);
  end

  always_comb begin
    for (int w = 0; w < blfa_pkg::WORDS; w++) begin
      word_ok[w] = (blfa_pkg::ADDR_W'(w) >= first_r[blfa_pkg::IDX_W-1:blfa_pkg::BIT_W])
                && ((blfa_pkg::ADDR_W+1)'(w) < lim_words);
    end
    cand = word_ok & ~full & ~tried_r;
  end

  assign num_m1  = num_r - blfa_pkg::NUM_W'(1);
  assign num_ok  = (num_r != '0) && (num_r <= CAP_N);
  assign num_one = blfa_pkg::WORD_W'(1) << num_m1[blfa_pkg::BIT_W-1:0];

  // bits of the row being checked that lie inside [first, limit)
  always_comb begin
    lo_mask = '1;
    hi_mask = '1;
    if (addr_r == first_r[blfa_pkg::IDX_W-1:blfa_pkg::BIT_W]) begin
      lo_mask = {blfa_pkg::WORD_W{1'b1}} << first_r[blfa_pkg::BIT_W-1:0];
    end
    if ({1'b0, addr_r} == limit[blfa_pkg::NUM_W-1:blfa_pkg::BIT_W]) begin
      hi_mask = ~({blfa_pkg::WORD_W{1'b1}} << limit[blfa_pkg::BIT_W-1:0]);
    end
    avail     = ~word & lo_mask & hi_mask;
    avail_one = avail & (~avail + blfa_pkg::WORD_W'(1));
    avail_bit = blfa_pkg::lowest_set(avail);
  end

  always_comb begin
    state_nxt    = state_r;
    tried_nxt    = tried_r;
    addr_nxt     = addr_r;
    res_num_nxt  = res_num_r;
    res_st_nxt   = res_st_r;
    free_cnt_nxt = free_cnt_r;
    map_req      = '0;
    unique case (state_r)
      S_IDLE: begin
        tried_nxt = '0;
        if (in_acc) begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        res_num_nxt = num_r;
        res_st_nxt  = blfa_pkg::ST_DONE;
        priority if (kind_r == blfa_pkg::REQ_ALLOC) begin
          if (|cand) begin
            addr_nxt        = blfa_pkg::lowest_set(cand);
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = addr_nxt;
            state_nxt       = S_CHK;
          end else begin
            res_num_nxt = '0;
            res_st_nxt  = blfa_pkg::ST_NONE_FREE;
            state_nxt   = S_OUT;
          end
        end else if (kind_r == blfa_pkg::REQ_FREE || kind_r == blfa_pkg::REQ_RESERVE) begin
          if (num_ok) begin
            addr_nxt        = num_m1[blfa_pkg::IDX_W-1:blfa_pkg::BIT_W];
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = addr_nxt;
            state_nxt       = S_CHK;
          end else begin
            if (kind_r == blfa_pkg::REQ_RESERVE) begin
              res_st_nxt = blfa_pkg::ST_IN_USE;
            end
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_CHK: begin
        map_req.wr_addr = addr_r;
        state_nxt       = S_OUT;
        priority if (kind_r == blfa_pkg::REQ_ALLOC) begin
          if (|avail) begin
            map_req.wr_en   = 1'b1;
            map_req.wr_data = word | avail_one;
            res_num_nxt     = blfa_pkg::NUM_W'({addr_r, avail_bit}) + blfa_pkg::NUM_W'(1);
            if (free_cnt_r != '0) begin
              free_cnt_nxt = free_cnt_r - blfa_pkg::NUM_W'(1);
            end
          end else begin
            // free bits of this row lie outside the scan window; try the next
            tried_nxt[addr_r] = 1'b1;
            state_nxt         = S_FIND;
          end
        end else if (kind_r == blfa_pkg::REQ_FREE) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_data = word & ~num_one;
          if (free_cnt_r < CAP_N) begin
            free_cnt_nxt = free_cnt_r + blfa_pkg::NUM_W'(1);
          end
        end else begin
          if (|(word & num_one)) begin
            res_st_nxt = blfa_pkg::ST_IN_USE;
          end else begin
            map_req.wr_en   = 1'b1;
            map_req.wr_data = word | num_one;
            if (free_cnt_r != '0) begin
              free_cnt_nxt = free_cnt_r - blfa_pkg::NUM_W'(1);
            end
          end
        end
      end
      S_OUT: begin
        if (out_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we && cfg_index == blfa_pkg::CFG_INITIAL_FREE) begin
      free_cnt_nxt = (cfg_wdata > CAP_N) ? CAP_N : cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tried_r     <= '0;
      free_cnt_r  <= CAP_N;
      total_r     <= CAP_N;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tried_r    <= tried_nxt;
      free_cnt_r <= free_cnt_nxt;
      if (cfg_we && cfg_index == blfa_pkg::CFG_TOTAL_ITEMS) begin
        total_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == blfa_pkg::CFG_FIRST_CANDIDATE) begin
        first_r <= cfg_wdata[blfa_pkg::IDX_W-1:0];
      end
      if (state_r == S_OUT && out_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    res_num_r <= res_num_nxt;
    res_st_r  <= res_st_nxt;
    if (in_acc) begin
      kind_r <= in_req_type;
      num_r  <= in_item_number;
    end
    if (state_r == S_OUT && out_take) begin
      out_num_r  <= res_num_r;
      out_st_r   <= res_st_r;
      out_free_r <= free_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_number = out_num_r;
  assign out_status        = out_st_r;
  assign out_free_left     = out_free_r;

endmodule
